// ===== design/clp_pkg.sv =====
// Shared types and constants for the convex layer peeling unit.
package clp_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int PTR_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = PTR_W + 1;
  localparam int COORD_BITS  = 24;
  localparam int ID_W        = 16;
  localparam int LAYER_W     = 5;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int STORE_W     = ID_W + 2 * COORD_BITS;
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [ID_W-1:0]              point_id;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic                         last_point;
  } in_beat_t;

  typedef struct packed {
    logic [ID_W-1:0]              out_id;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic [LAYER_W-1:0]           layer_number;
    logic                         end_of_layer;
    logic                         end_of_run;
  } out_beat_t;

  typedef struct packed {
    logic [ID_W-1:0]              id;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } store_t;

  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } q_link_t;

  typedef struct packed {
    logic busy;
    logic peeling;
  } bk_status_t;

endpackage

// ===== design/clp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module clp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/clp_front.sv =====
// Input side: accepts point beats and queues them for the peeling engine.
module clp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  clp_pkg::in_beat_t in_data,
  output clp_pkg::q_link_t  q_link,
  input  logic              q_pop
);

  clp_pkg::in_beat_t             slot_r [clp_pkg::QUEUE_DEPTH];
  logic                          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [clp_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          push;

  assign in_stall = (cnt_r == clp_pkg::QCNT_W'(clp_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;

  assign q_link.valid = (cnt_r != '0);
  assign q_link.beat  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + clp_pkg::QCNT_W'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - clp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= in_data;
    end
  end

endmodule

// ===== design/clp_back.sv =====
// Peeling engine: stores points, sorts them, runs the monotone chains, emits layers.
module clp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  clp_pkg::q_link_t    q_link,
  output logic                q_pop,
  input  logic                out_stall,
  output logic                out_valid,
  output clp_pkg::out_beat_t  out_data,
  output clp_pkg::bk_status_t status
);

  localparam int PW = clp_pkg::PTR_W;
  localparam int CW = clp_pkg::CNT_W;
  localparam int XW = clp_pkg::COORD_BITS;
  localparam int DW = clp_pkg::DIFF_W;
  localparam int MW = clp_pkg::PROD_W;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SRT_I   = 5'd1;
  localparam logic [4:0] S_SRT_IW  = 5'd2;
  localparam logic [4:0] S_SRT_J   = 5'd3;
  localparam logic [4:0] S_SRT_JC  = 5'd4;
  localparam logic [4:0] S_LO_ADDR = 5'd5;
  localparam logic [4:0] S_LO_ORD  = 5'd6;
  localparam logic [4:0] S_PT      = 5'd7;
  localparam logic [4:0] S_CHK     = 5'd8;
  localparam logic [4:0] S_T1      = 5'd9;
  localparam logic [4:0] S_T2      = 5'd10;
  localparam logic [4:0] S_T3      = 5'd11;
  localparam logic [4:0] S_POP_S   = 5'd12;
  localparam logic [4:0] S_POP_D   = 5'd13;
  localparam logic [4:0] S_RM_ADDR = 5'd14;
  localparam logic [4:0] S_RM_CLR  = 5'd15;
  localparam logic [4:0] S_UP_ADDR = 5'd16;
  localparam logic [4:0] S_UP_ORD  = 5'd17;
  localparam logic [4:0] S_EM_ADDR = 5'd18;
  localparam logic [4:0] S_EM_SLOT = 5'd19;
  localparam logic [4:0] S_EM_DATA = 5'd20;

  logic [4:0]                      state_r, state_nxt;
  logic [CW-1:0]                   n_r, n_nxt, cnt_r, cnt_nxt;
  logic [clp_pkg::MAX_POINTS-1:0]  present_r, present_nxt;
  logic [PW-1:0]                   i_r, i_nxt, rank_r, rank_nxt, pslot_r, pslot_nxt;
  logic [CW-1:0]                   j_r, j_nxt, k_r, k_nxt, jm1;
  logic [CW-1:0]                   sp_r, sp_nxt, lowtop_r, lowtop_nxt, hn_r, hn_nxt;
  logic [clp_pkg::LAYER_W-1:0]     layer_r, layer_nxt;
  logic                            upper_r, upper_nxt, first_r, first_nxt;
  logic                            final_r, final_nxt;
  logic                            out_valid_r, out_valid_nxt;
  clp_pkg::out_beat_t              out_data_r, out_data_nxt;

  logic signed [XW-1:0] ix_r, ix_nxt, iy_r, iy_nxt;
  logic [clp_pkg::ID_W-1:0] iid_r, iid_nxt;
  logic signed [XW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [XW-1:0] ax_r, ax_nxt, ay_r, ay_nxt, bx_r, bx_nxt, by_r, by_nxt;
  logic signed [DW-1:0] dbx_r, dbx_nxt, dpy_r, dpy_nxt, dby_r, dby_nxt, dpx_r, dpx_nxt;
  logic signed [MW-1:0] pp_r, pp_nxt, pq_r, pq_nxt;

  logic                        st_we, ord_we, stk_we;
  logic [PW-1:0]               st_wa, st_ra, ord_wa, ord_wd, ord_ra, ord_rd;
  logic [PW-1:0]               stk_wa, stk_wd, stk_ra, stk_rd;
  logic [clp_pkg::STORE_W-1:0] st_wd_raw, st_rd_raw;
  clp_pkg::store_t             st_wd, st_rd;
  logic                        j_ahead, do_push, eol;
  logic [CW-1:0]               floor_sp, hn_calc;

  assign st_wd_raw = st_wd;
  assign st_rd     = st_rd_raw;
  assign jm1       = j_r - CW'(1);

  clp_ram #(.WIDTH(clp_pkg::STORE_W), .DEPTH(clp_pkg::MAX_POINTS)) u_store (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd_raw), .raddr(st_ra), .rdata(st_rd_raw)
  );

  clp_ram #(.WIDTH(PW), .DEPTH(clp_pkg::MAX_POINTS)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd)
  );

  clp_ram #(.WIDTH(PW), .DEPTH(clp_pkg::MAX_POINTS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
  );

  // slot j sorts ahead of slot i: x, then y, then id, then slot
  assign j_ahead = (st_rd.x < ix_r) ||
                   ((st_rd.x == ix_r) && ((st_rd.y < iy_r) ||
                   ((st_rd.y == iy_r) && ((st_rd.id < iid_r) ||
                   ((st_rd.id == iid_r) && (j_r[PW-1:0] < i_r))))));

  assign floor_sp = upper_r ? (lowtop_r + CW'(1)) : CW'(2);
  // the upper chain closes on the first point again, so that copy is not emitted
  assign hn_calc  = (sp_r == lowtop_r) ? lowtop_r : (sp_r - CW'(1));
  assign eol      = ((k_r + CW'(1)) == hn_r);

  always_comb begin
    state_nxt    = state_r;
    n_nxt        = n_r;
    cnt_nxt      = cnt_r;
    present_nxt  = present_r;
    i_nxt        = i_r;
    rank_nxt     = rank_r;
    pslot_nxt    = pslot_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    sp_nxt       = sp_r;
    lowtop_nxt   = lowtop_r;
    hn_nxt       = hn_r;
    layer_nxt    = layer_r;
    upper_nxt    = upper_r;
    first_nxt    = first_r;
    final_nxt    = final_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    ix_nxt = ix_r;  iy_nxt = iy_r;  iid_nxt = iid_r;
    px_nxt = px_r;  py_nxt = py_r;
    ax_nxt = ax_r;  ay_nxt = ay_r;  bx_nxt = bx_r;  by_nxt = by_r;
    dbx_nxt = dbx_r;  dpy_nxt = dpy_r;  dby_nxt = dby_r;  dpx_nxt = dpx_r;
    pp_nxt = pp_r;  pq_nxt = pq_r;
    q_pop  = 1'b0;
    st_we  = 1'b0;  st_wa  = '0;  st_wd = '0;  st_ra = '0;
    ord_we = 1'b0;  ord_wa = '0;  ord_wd = '0; ord_ra = '0;
    stk_we = 1'b0;  stk_wa = '0;  stk_wd = '0; stk_ra = '0;
    do_push = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_link.valid) begin
          q_pop = 1'b1;
          if (n_r < CW'(clp_pkg::MAX_POINTS)) begin
            st_we    = 1'b1;
            st_wa    = n_r[PW-1:0];
            st_wd.id = q_link.beat.point_id;
            st_wd.x  = q_link.beat.x_coord;
            st_wd.y  = q_link.beat.y_coord;
            present_nxt[n_r[PW-1:0]] = 1'b1;
            n_nxt   = n_r + CW'(1);
            cnt_nxt = cnt_r + CW'(1);
          end
          if (q_link.beat.last_point) begin
            i_nxt     = '0;
            state_nxt = S_SRT_I;
          end
        end
      end
      S_SRT_I: begin
        st_ra     = i_r;
        state_nxt = S_SRT_IW;
      end
      S_SRT_IW: begin
        ix_nxt    = st_rd.x;
        iy_nxt    = st_rd.y;
        iid_nxt   = st_rd.id;
        rank_nxt  = '0;
        j_nxt     = '0;
        state_nxt = S_SRT_J;
      end
      S_SRT_J: begin
        st_ra     = j_r[PW-1:0];
        state_nxt = S_SRT_JC;
      end
      S_SRT_JC: begin
        rank_nxt = rank_r + PW'(j_ahead);
        if ((j_r + CW'(1)) == n_r) begin
          ord_we = 1'b1;
          ord_wa = rank_nxt;
          ord_wd = i_r;
          i_nxt  = i_r + PW'(1);
          if (({1'b0, i_r} + CW'(1)) == n_r) begin
            j_nxt     = '0;
            sp_nxt    = '0;
            upper_nxt = 1'b0;
            layer_nxt = '0;
            state_nxt = S_LO_ADDR;
          end else begin
            state_nxt = S_SRT_I;
          end
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_SRT_J;
        end
      end
      S_LO_ADDR: begin
        if (j_r == n_r) begin
          lowtop_nxt = sp_r;
          k_nxt      = CW'(1);
          state_nxt  = S_RM_ADDR;
        end else begin
          ord_ra    = j_r[PW-1:0];
          state_nxt = S_LO_ORD;
        end
      end
      S_LO_ORD: begin
        j_nxt = j_r + CW'(1);
        if (present_r[ord_rd]) begin
          pslot_nxt = ord_rd;
          st_ra     = ord_rd;
          state_nxt = S_PT;
        end else begin
          state_nxt = S_LO_ADDR;
        end
      end
      S_PT: begin
        px_nxt    = st_rd.x;
        py_nxt    = st_rd.y;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sp_r >= floor_sp) begin
          state_nxt = S_T1;
        end else begin
          do_push = 1'b1;
        end
      end
      S_T1: begin
        dbx_nxt   = DW'(bx_r) - DW'(ax_r);
        dpy_nxt   = DW'(py_r) - DW'(ay_r);
        dby_nxt   = DW'(by_r) - DW'(ay_r);
        dpx_nxt   = DW'(px_r) - DW'(ax_r);
        state_nxt = S_T2;
      end
      S_T2: begin
        pp_nxt    = dbx_r * dpy_r;
        pq_nxt    = dby_r * dpx_r;
        state_nxt = S_T3;
      end
      S_T3: begin
        if (pp_r > pq_r) begin
          do_push = 1'b1;
        end else begin
          // drop the top, then refill the second entry from the stack
          sp_nxt = sp_r - CW'(1);
          bx_nxt = ax_r;
          by_nxt = ay_r;
          if (sp_r >= CW'(3)) begin
            stk_ra    = PW'(sp_r - CW'(3));
            state_nxt = S_POP_S;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end
      S_POP_S: begin
        st_ra     = stk_rd;
        state_nxt = S_POP_D;
      end
      S_POP_D: begin
        ax_nxt    = st_rd.x;
        ay_nxt    = st_rd.y;
        state_nxt = S_CHK;
      end
      S_RM_ADDR: begin
        if ((k_r + CW'(1)) < lowtop_r) begin
          stk_ra    = k_r[PW-1:0];
          state_nxt = S_RM_CLR;
        end else begin
          j_nxt     = n_r;
          first_nxt = 1'b1;
          upper_nxt = 1'b1;
          state_nxt = S_UP_ADDR;
        end
      end
      S_RM_CLR: begin
        present_nxt[stk_rd] = 1'b0;
        k_nxt     = k_r + CW'(1);
        state_nxt = S_RM_ADDR;
      end
      S_UP_ADDR: begin
        if (j_r == '0) begin
          hn_nxt    = hn_calc;
          final_nxt = (hn_calc < CW'(3)) || (cnt_r == hn_calc);
          k_nxt     = '0;
          state_nxt = S_EM_ADDR;
        end else begin
          ord_ra    = jm1[PW-1:0];
          state_nxt = S_UP_ORD;
        end
      end
      S_UP_ORD: begin
        j_nxt     = jm1;
        state_nxt = S_UP_ADDR;
        if (present_r[ord_rd]) begin
          if (first_r) begin
            // rightmost point already sits on top of the stack
            first_nxt = 1'b0;
          end else begin
            pslot_nxt = ord_rd;
            st_ra     = ord_rd;
            state_nxt = S_PT;
          end
        end
      end
      S_EM_ADDR: begin
        if (k_r == sp_r) begin
          if (final_r) begin
            present_nxt = '0;
            n_nxt       = '0;
            cnt_nxt     = '0;
            state_nxt   = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r - hn_r;
            layer_nxt = layer_r + clp_pkg::LAYER_W'(1);
            sp_nxt    = '0;
            j_nxt     = '0;
            upper_nxt = 1'b0;
            state_nxt = S_LO_ADDR;
          end
        end else begin
          stk_ra    = k_r[PW-1:0];
          state_nxt = S_EM_SLOT;
        end
      end
      S_EM_SLOT: begin
        present_nxt[stk_rd] = 1'b0;
        pslot_nxt = stk_rd;
        st_ra     = stk_rd;
        if (k_r < hn_r) begin
          state_nxt = S_EM_DATA;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_EM_ADDR;
        end
      end
      S_EM_DATA: begin
        st_ra = pslot_r;
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.out_id       = st_rd.id;
          out_data_nxt.out_x        = st_rd.x;
          out_data_nxt.out_y        = st_rd.y;
          out_data_nxt.layer_number = layer_r;
          out_data_nxt.end_of_layer = eol;
          out_data_nxt.end_of_run   = eol && final_r;
          k_nxt     = k_r + CW'(1);
          state_nxt = S_EM_ADDR;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_push) begin
      stk_we    = 1'b1;
      stk_wa    = sp_r[PW-1:0];
      stk_wd    = pslot_r;
      ax_nxt    = bx_r;
      ay_nxt    = by_r;
      bx_nxt    = px_r;
      by_nxt    = py_r;
      sp_nxt    = sp_r + CW'(1);
      state_nxt = upper_r ? S_UP_ADDR : S_LO_ADDR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      cnt_r       <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      rank_r      <= '0;
      sp_r        <= '0;
      lowtop_r    <= '0;
      hn_r        <= '0;
      layer_r     <= '0;
      upper_r     <= 1'b0;
      first_r     <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      rank_r      <= rank_nxt;
      sp_r        <= sp_nxt;
      lowtop_r    <= lowtop_nxt;
      hn_r        <= hn_nxt;
      layer_r     <= layer_nxt;
      upper_r     <= upper_nxt;
      first_r     <= first_nxt;
      final_r     <= final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    pslot_r    <= pslot_nxt;
    ix_r  <= ix_nxt;   iy_r  <= iy_nxt;   iid_r <= iid_nxt;
    px_r  <= px_nxt;   py_r  <= py_nxt;
    ax_r  <= ax_nxt;   ay_r  <= ay_nxt;   bx_r  <= bx_nxt;   by_r <= by_nxt;
    dbx_r <= dbx_nxt;  dpy_r <= dpy_nxt;  dby_r <= dby_nxt;  dpx_r <= dpx_nxt;
    pp_r  <= pp_nxt;   pq_r  <= pq_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign status.busy    = (state_r != S_IDLE);
  assign status.peeling = (state_r != S_IDLE) && (state_r != S_SRT_I) &&
                          (state_r != S_SRT_IW) && (state_r != S_SRT_J) &&
                          (state_r != S_SRT_JC);

endmodule

// ===== design/convex_layer_peeling_unit.sv =====
// Points load one per cycle through a two-entry queue while idle; peeling starts after the last point.
// Sorting ranks each of the n points against all n on the single store read port.
// A chain point is fetched via the order and store reads, then pushed unchecked or turn-checked,
// with a stack and store refetch per pop that needs one; absent points are skipped.
// Emit reads stack, then store, and waits for a free output; new points wait until the run ends.
// Reset clears the queue, point count, presence bits and output valid; the stores are not cleared.
module convex_layer_peeling_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  clp_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output clp_pkg::out_beat_t out_data
);

  clp_pkg::q_link_t    q_link;
  logic                q_pop;
  clp_pkg::bk_status_t bk_status;

  clp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_link(q_link), .q_pop(q_pop)
  );

  clp_back u_back (
    .clk(clk), .rst_n(rst_n), .q_link(q_link), .q_pop(q_pop),
    .out_stall(out_stall), .out_valid(out_valid), .out_data(out_data), .status(bk_status)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_link.valid) else $error("queue popped while empty");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !bk_status.busy) else $error("point beat taken during a run");

  a_emit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_status.peeling)) else $error("result outside peeling");

endmodule
